// ----- src/grvec_pkg.sv -----
// ----------------------------------------------------------------------------
// grvec_pkg: shared types and constants
// Opcodes, status codes, field widths and the front-to-back command struct.
// ----------------------------------------------------------------------------
package grvec_pkg;

   localparam int CoordWidth  = 8;
   localparam int SizeWidth   = 9;
   localparam int PrefixWidth = 17;
   localparam int CountWidth  = 18;
   localparam int StatusWidth = 2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [StatusWidth-1:0] ST_OK       = 2'd0;
   localparam logic [StatusWidth-1:0] ST_NOT_DONE = 2'd1;
   localparam logic [StatusWidth-1:0] ST_BAD_RECT = 2'd2;

   localparam logic CSR_ROW_COUNT    = 1'b0;
   localparam logic CSR_COLUMN_COUNT = 1'b1;

   // classified command handed from front to back
   typedef struct packed {
      logic                         is_query;
      logic [StatusWidth-1:0]       status;
      logic                         pixel;
      logic                         left_px;
      logic                         up_px;
      logic [CoordWidth-1:0]        top_row;
      logic [CoordWidth-1:0]        left_column;
      logic [CoordWidth-1:0]        bottom_row;
      logic [CoordWidth-1:0]        right_column;
      logic [11:0]                  row;
      logic [11:0]                  col;
   } cmd_type;

endpackage

// ----- src/grvec_if.sv -----
// ----------------------------------------------------------------------------
// grvec_req_if / grvec_rsp_if: valid/ready channels
// Request and response channels with source and sink modports.
// ----------------------------------------------------------------------------
interface grvec_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic       pixel;
   logic [7:0] top_row;
   logic [7:0] left_column;
   logic [7:0] bottom_row;
   logic [7:0] right_column;
   modport source (output valid, opcode, pixel, top_row, left_column, bottom_row,
                   right_column, input ready);
   modport sink (input valid, opcode, pixel, top_row, left_column, bottom_row,
                 right_column, output ready);
endinterface

interface grvec_rsp_if;
   logic        valid;
   logic        ready;
   logic [17:0] region_count;
   logic [1:0]  status;
   modport source (output valid, region_count, status, input ready);
   modport sink (input valid, region_count, status, output ready);
endinterface

// ----- src/grvec_front.sv -----
// ----------------------------------------------------------------------------
// grvec_front: load tracking and classification
// Tracks the raster position and the previous row of pixels, checks queries
// and produces one command per accepted item, except loads after the image is complete.
// ----------------------------------------------------------------------------
module grvec_front #(
   parameter int MAX_ROWS    = 256,
   parameter int MAX_COLUMNS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [8:0]                   csr_data,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         opcode,
   input  logic                         pixel,
   input  logic [7:0]                   top_row,
   input  logic [7:0]                   left_column,
   input  logic [7:0]                   bottom_row,
   input  logic [7:0]                   right_column,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output grvec_pkg::cmd_type           cmd
);
   import grvec_pkg::*;

   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int SW = $clog2(MAX_COLUMNS + 1);

   logic [RW-1:0] row_count_ff, load_row_ff;
   logic [SW-1:0] col_count_ff;
   logic [CW-1:0] load_col_ff;
   logic [MAX_COLUMNS-1:0] prev_ff;
   logic [RW-1:0] rc_in;
   logic [SW-1:0] cc_in;
   logic done, accept, last_col, up_px, left_px, bad;

   // clamp register writes into range
   always_comb begin
      if (csr_data == '0) rc_in = RW'(1);
      else if ({23'd0, csr_data} > MAX_ROWS) rc_in = RW'(MAX_ROWS);
      else rc_in = RW'(csr_data);
      if (csr_data == '0) cc_in = SW'(1);
      else if ({23'd0, csr_data} > MAX_COLUMNS) cc_in = SW'(MAX_COLUMNS);
      else cc_in = SW'(csr_data);
   end

   assign done     = load_row_ff >= row_count_ff;
   assign in_ready = cmd_ready;
   assign accept   = in_valid && in_ready;
   assign last_col = (SW'(load_col_ff) + SW'(1)) >= col_count_ff;
   assign up_px    = prev_ff[load_col_ff];
   assign left_px  = (load_col_ff != '0) ? prev_ff[load_col_ff - 1'b1] : 1'b0;
   assign bad = (top_row > bottom_row) || (left_column > right_column) ||
                ({24'd0, bottom_row} >= 32'(row_count_ff)) ||
                ({24'd0, right_column} >= 32'(col_count_ff));

   // load position, previous row, sizes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= RW'(MAX_ROWS);
         col_count_ff <= SW'(MAX_COLUMNS);
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         prev_ff      <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_ROW_COUNT) row_count_ff <= rc_in;
         else col_count_ff <= cc_in;
         load_row_ff <= '0;
         load_col_ff <= '0;
         prev_ff     <= '0;
      end else if (accept && opcode == OP_LOAD && !done) begin
         prev_ff[load_col_ff] <= pixel;
         if (last_col) begin
            load_col_ff <= '0;
            load_row_ff <= load_row_ff + 1'b1;
         end else begin
            load_col_ff <= load_col_ff + 1'b1;
         end
      end
   end

   // command out; loads after completion are dropped
   always_comb begin
      cmd_valid        = accept && !(opcode == OP_LOAD && done);
      cmd.is_query     = opcode == OP_QUERY;
      cmd.status       = !done ? ST_NOT_DONE : (bad ? ST_BAD_RECT : ST_OK);
      cmd.pixel        = pixel;
      cmd.left_px      = left_px;
      cmd.up_px        = up_px;
      cmd.top_row      = top_row;
      cmd.left_column  = left_column;
      cmd.bottom_row   = bottom_row;
      cmd.right_column = right_column;
      cmd.row          = 12'(load_row_ff);
      cmd.col          = 12'(load_col_ff);
   end

   a_load_col_in_width: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == OP_LOAD && !done) |-> (SW'(load_col_ff) < col_count_ff))
      else $error("load column beyond width");
   a_load_row_in_height: assert property (@(posedge clock) disable iff (reset)
      load_row_ff <= row_count_ff)
      else $error("load row beyond height");
   a_query_forwarded: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == OP_QUERY) |-> cmd_valid)
      else $error("query not forwarded");
endmodule

// ----- src/grvec_back.sv -----
// ----------------------------------------------------------------------------
// grvec_back: table sequencer
// Runs loads and queries against three single-port prefix memories; a
// short command queue decouples it from the front.
// ----------------------------------------------------------------------------
module grvec_back #(
   parameter int MAX_ROWS    = 256,
   parameter int MAX_COLUMNS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  grvec_pkg::cmd_type    cmd,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [17:0]           region_count,
   output logic [1:0]            status
);
   import grvec_pkg::*;

   localparam int RB = $clog2(MAX_ROWS);
   localparam int CB = $clog2(MAX_COLUMNS);
   localparam int AW = RB + CB;
   localparam int DEPTH = 1 << AW;

   typedef enum logic [2:0] {S_IDLE, S_READ, S_ACC, S_WRITE, S_OUT} state_type;

   // two-entry queue
   cmd_type q_ff [2];
   logic [1:0] cnt_ff;
   logic       rd_ff, wr_ff;
   logic       pop;
   cmd_type    cur;

   assign cmd_ready = cnt_ff != 2'd2;
   assign cur = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready) q_ff[wr_ff] <= cmd;
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (cmd_valid && cmd_ready) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(cmd_valid && cmd_ready) - 2'(pop);
      end
   end

   // memories
   logic [PrefixWidth-1:0] mem_p [DEPTH];
   logic [PrefixWidth-1:0] mem_h [DEPTH];
   logic [PrefixWidth-1:0] mem_v [DEPTH];
   logic [PrefixWidth-1:0] dp_ff, dh_ff, dv_ff;
   logic [AW-1:0] addr_p, addr_h, addr_v, addr_w;
   logic          we;
   logic [PrefixWidth-1:0] wp, wh, wv;

   // sequencer state
   state_type state_ff;
   logic [1:0] k_ff;
   logic       rvalid_p_ff, rvalid_h_ff, rvalid_v_ff;
   logic       kneg_ff;
   logic       live_ff;
   logic [PrefixWidth+1:0] ap_ff, ah_ff, av_ff;
   logic [PrefixWidth+1:0] ap_in, ah_in, av_in;
   logic [PrefixWidth+1:0] addp, addh, addv;
   logic [CountWidth-1:0]  res_ff;
   logic [1:0]             st_ff;

   logic [12:0] rp, cp, rh, ch, rv, cv;
   logic        neg;
   logic        inb_p, inb_h, inb_v;
   logic [12:0] t0, t1, l0, l1, bb, rr0, rw, cl;

   // corner lies inside the table; negative or past the edge reads as zero
   function automatic logic in_table(logic [12:0] row_i, logic [12:0] col_i);
      return !row_i[12] && !col_i[12] && row_i < 13'(MAX_ROWS) &&
             col_i < 13'(MAX_COLUMNS);
   endfunction

   // per-read corner of each table, sign and address
   always_comb begin
      bb  = {5'd0, cur.bottom_row};
      rr0 = {5'd0, cur.right_column};
      t0  = {5'd0, cur.top_row};
      t1  = t0 - 13'd1;
      l0  = {5'd0, cur.left_column};
      l1  = l0 - 13'd1;
      rw  = {1'b0, cur.row};
      cl  = {1'b0, cur.col};
      if (cur.is_query) begin
         // k[1] picks the top edge, k[0] the left edge
         rp = k_ff[1] ? t1 : bb;
         cp = k_ff[0] ? l1 : rr0;
         // horizontal pairs start one column in, vertical pairs one row in
         rh = rp;
         ch = k_ff[0] ? l0 : rr0;
         rv = k_ff[1] ? t0 : bb;
         cv = cp;
         neg = k_ff[1] ^ k_ff[0];
      end else begin
         // corners: up, left, up-left
         rp = (k_ff == 2'd1) ? rw : rw - 13'd1;
         cp = (k_ff == 2'd0) ? cl : cl - 13'd1;
         rh = rp;
         ch = cp;
         rv = rp;
         cv = cp;
         neg = k_ff == 2'd2;
      end
      inb_p  = in_table(rp, cp);
      inb_h  = in_table(rh, ch);
      inb_v  = in_table(rv, cv);
      addr_w = {rw[RB-1:0], cl[CB-1:0]};
      if (we) begin
         addr_p = addr_w;
         addr_h = addr_w;
         addr_v = addr_w;
      end else begin
         addr_p = {rp[RB-1:0], cp[CB-1:0]};
         addr_h = {rh[RB-1:0], ch[CB-1:0]};
         addr_v = {rv[RB-1:0], cv[CB-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_p[addr_p] <= wp; mem_h[addr_h] <= wh; mem_v[addr_v] <= wv;
      end
      dp_ff <= mem_p[addr_p]; dh_ff <= mem_h[addr_h]; dv_ff <= mem_v[addr_v];
   end

   assign we = state_ff == S_WRITE;
   assign wp = PrefixWidth'(ap_ff + {18'd0, cur.pixel});
   assign wh = PrefixWidth'(ah_ff + {18'd0, cur.pixel & cur.left_px});
   assign wv = PrefixWidth'(av_ff + {18'd0, cur.pixel & cur.up_px});
   assign pop = (state_ff == S_WRITE) || (state_ff == S_OUT && out_ready);

   // accumulate the previous read's data; cleared while idle
   always_comb begin
      addp = rvalid_p_ff ? {2'd0, dp_ff} : '0;
      addh = rvalid_h_ff ? {2'd0, dh_ff} : '0;
      addv = rvalid_v_ff ? {2'd0, dv_ff} : '0;
      ap_in = ap_ff;
      ah_in = ah_ff;
      av_in = av_ff;
      if (state_ff == S_IDLE) begin
         ap_in = '0;
         ah_in = '0;
         av_in = '0;
      end else if (live_ff) begin
         ap_in = kneg_ff ? ap_ff - addp : ap_ff + addp;
         ah_in = kneg_ff ? ah_ff - addh : ah_ff + addh;
         av_in = kneg_ff ? av_ff - addv : av_ff + addv;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; k_ff <= '0; live_ff <= 1'b0;
         rvalid_p_ff <= 1'b0; rvalid_h_ff <= 1'b0; rvalid_v_ff <= 1'b0;
         kneg_ff <= 1'b0;
         ap_ff <= '0; ah_ff <= '0; av_ff <= '0;
         res_ff <= '0; st_ff <= ST_OK;
      end else begin
         ap_ff <= ap_in; ah_ff <= ah_in; av_ff <= av_in;
         case (state_ff)
            S_IDLE: if (cnt_ff != 2'd0) begin
               k_ff <= '0;
               live_ff <= 1'b0;
               if (cur.is_query && cur.status != ST_OK) begin
                  res_ff <= '0; st_ff <= cur.status; state_ff <= S_OUT;
               end else state_ff <= S_READ;
            end
            S_READ: begin
               live_ff <= 1'b1;
               rvalid_p_ff <= inb_p; rvalid_h_ff <= inb_h; rvalid_v_ff <= inb_v;
               kneg_ff <= neg;
               if (k_ff == (cur.is_query ? 2'd3 : 2'd2)) state_ff <= S_ACC;
               else k_ff <= k_ff + 1'b1;
            end
            S_ACC: begin
               live_ff <= 1'b0;
               // last read lands now: set pixels minus both pair boxes
               if (cur.is_query) begin
                  res_ff <= CountWidth'(ap_in - ah_in - av_in);
                  st_ff  <= ST_OK;
               end
               state_ff <= cur.is_query ? S_OUT : S_WRITE;
            end
            S_WRITE: state_ff <= S_IDLE;
            S_OUT: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign out_valid    = state_ff == S_OUT;
   assign region_count = res_ff;
   assign status       = st_ff;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_out_has_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (cnt_ff != 2'd0))
      else $error("output with empty queue");
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      we |-> !cur.is_query)
      else $error("query wrote a table");
   a_out_stable: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(region_count) &&
                                     $stable(status)))
      else $error("result changed while stalled");
endmodule

// ----- src/grid_region_vertex_edge_count.sv -----
// ----------------------------------------------------------------------------
// grid_region_vertex_edge_count: online summed-area region counter
// Loads a binary image and answers rectangle queries of set pixels minus
// inner adjacent set pairs.
//
//  channel | dir | payload
//  req     | in  | opcode, pixel, top_row, left_column, bottom_row, right_column
//  rsp     | out | region_count, status
//  csr     | in  | csr_write, csr_index, csr_data
//
// Loads read three corners and queries four from the single-port prefix memories.
// Rejected queries skip the reads. Reset is synchronous; memories are not
// cleared. A two-entry queue lets the front take items while a result waits.
// ----------------------------------------------------------------------------
module grid_region_vertex_edge_count #(
   parameter int MAX_ROWS    = 256,
   parameter int MAX_COLUMNS = 256
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write,
   input  logic           csr_index,
   input  logic [8:0]     csr_data,
   grvec_req_if.sink      req,
   grvec_rsp_if.source    rsp
);
   import grvec_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   grvec_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .in_valid(req.valid), .in_ready(req.ready), .opcode(req.opcode),
      .pixel(req.pixel), .top_row(req.top_row), .left_column(req.left_column),
      .bottom_row(req.bottom_row), .right_column(req.right_column),
      .cmd_valid, .cmd_ready, .cmd);

   grvec_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .region_count(rsp.region_count), .status(rsp.status));
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for grid_region_vertex_edge_count
// Loads binary images of several sizes pixel by pixel and asks rectangle
// queries. Each answer is checked against a local image copy that counts set
// pixels minus adjacent set pairs directly. Covers queries during a load,
// bad rectangles, ignored extra loads, size clamping and output back-pressure.
// ----------------------------------------------------------------------------
module tb;
   import grvec_pkg::*;

   typedef struct {
      logic [CountWidth-1:0]  count;
      logic [StatusWidth-1:0] status;
   } answer_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic csr_index;
   logic [8:0] csr_data;

   grvec_req_if req_ch ();
   grvec_rsp_if rsp_ch ();

   grid_region_vertex_edge_count dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   // local copy of the image and load position
   bit          image [256][256];
   int unsigned n_rows, n_cols, ld_row, ld_col;
   answer_type  pending_answers [$];
   int          fail_count;
   int          answers_seen;
   int          items_sent;
   int          hold_left;
   int          stall_left;
   longint      cycle_count;

   // clock and cycle limit
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 3000000) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic int unsigned clamp_size(int unsigned v);
      if (v < 1) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   // set pixels minus horizontal and vertical set pairs inside the rectangle
   function automatic answer_type region_answer(int t, int l, int b, int r);
      answer_type a;
      int s;
      s = 0;
      a.count = '0;
      if (ld_row < n_rows) begin
         a.status = ST_NOT_DONE;
         return a;
      end
      if (t > b || l > r || b >= n_rows || r >= n_cols) begin
         a.status = ST_BAD_RECT;
         return a;
      end
      for (int i = t; i <= b; i++)
         for (int j = l; j <= r; j++)
            if (image[i][j]) begin
               s++;
               if (j > l && image[i][j-1]) s--;
               if (i > t && image[i-1][j]) s--;
            end
      a.count = s[CountWidth-1:0];
      a.status = ST_OK;
      return a;
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready = 1'b1;
         if ($urandom_range(0, 9) == 0)
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         answer_type e;
         answers_seen++;
         if (pending_answers.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result count=%0d status=%0d", $time,
                     rsp_ch.region_count, rsp_ch.status);
         end else begin
            e = pending_answers.pop_front();
            if (e.count !== rsp_ch.region_count || e.status !== rsp_ch.status) begin
               fail_count++;
               $display("%0t: expected count=%0d status=%0d, actual count=%0d status=%0d",
                        $time, $signed(e.count), e.status,
                        $signed(rsp_ch.region_count), rsp_ch.status);
            end
         end
      end
   end

   // send one item; prediction happens at the transfer
   task automatic send_item(logic op, logic pix, int t, int l, int b, int r, bit gaps);
      int gap;
      req_ch.valid        = 1'b1;
      req_ch.opcode       = op;
      req_ch.pixel        = pix;
      req_ch.top_row      = t[CoordWidth-1:0];
      req_ch.left_column  = l[CoordWidth-1:0];
      req_ch.bottom_row   = b[CoordWidth-1:0];
      req_ch.right_column = r[CoordWidth-1:0];
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (op == OP_QUERY) begin
         // predict from the coordinates as driven on the port
         pending_answers.push_back(region_answer(int'(t[CoordWidth-1:0]),
                                                 int'(l[CoordWidth-1:0]),
                                                 int'(b[CoordWidth-1:0]),
                                                 int'(r[CoordWidth-1:0])));
      end else if (ld_row < n_rows) begin
         image[ld_row][ld_col] = pix;
         ld_col++;
         if (ld_col >= n_cols) begin
            ld_col = 0;
            ld_row++;
         end
      end
      @(negedge clock);
      gap = 0;
      if (gaps && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 2);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic end_burst();
      req_ch.valid = 1'b0;
   endtask

   // wait until every answer is back and the block has settled
   task automatic drain();
      end_burst();
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_size(logic idx, int unsigned value);
      drain();
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = value[8:0];
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == CSR_ROW_COUNT) n_rows = clamp_size({23'd0, value[8:0]});
      else n_cols = clamp_size({23'd0, value[8:0]});
      ld_row = 0;
      ld_col = 0;
   endtask

   task automatic set_size(int unsigned rows, int unsigned cols);
      write_size(CSR_ROW_COUNT, rows);
      write_size(CSR_COLUMN_COUNT, cols);
   endtask

   task automatic load_image(int density, bit gaps);
      int total;
      total = n_rows * n_cols;
      for (int k = 0; k < total; k++)
         send_item(OP_LOAD, $urandom_range(0, 99) < density, $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), gaps);
   endtask

   task automatic good_query(bit gaps);
      int t, l, b, r;
      t = $urandom_range(0, n_rows - 1);
      b = $urandom_range(t, n_rows - 1);
      l = $urandom_range(0, n_cols - 1);
      r = $urandom_range(l, n_cols - 1);
      send_item(OP_QUERY, $urandom_range(0, 1), t, l, b, r, gaps);
   endtask

   task automatic wild_query(bit gaps);
      send_item(OP_QUERY, $urandom_range(0, 1), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), gaps);
   endtask

   // smallest size from zero writes; extra loads ignored
   task automatic test_tiny_image();
      set_size(0, 0);
      send_item(OP_QUERY, 1'b0, 0, 0, 0, 0, 1'b0);
      send_item(OP_LOAD, 1'b1, 0, 0, 0, 0, 1'b0);
      send_item(OP_LOAD, 1'b0, 0, 0, 0, 0, 1'b0);
      send_item(OP_QUERY, 1'b0, 0, 0, 0, 0, 1'b0);
      send_item(OP_QUERY, 1'b0, 0, 0, 1, 0, 1'b0);
      send_item(OP_QUERY, 1'b0, 0, 0, 0, 1, 1'b0);
   endtask

   // fixed pattern with every status
   task automatic test_directed_pattern();
      bit pattern [12];
      pattern = '{1, 1, 0, 1, 0, 1, 0, 1, 1, 1, 1, 0};
      set_size(3, 4);
      for (int k = 0; k < 12; k++) begin
         send_item(OP_LOAD, pattern[k], 0, 0, 0, 0, 1'b0);
         if (k == 5) send_item(OP_QUERY, 1'b0, 0, 0, 0, 0, 1'b0);
      end
      send_item(OP_QUERY, 1'b1, 0, 0, 2, 3, 1'b0);
      send_item(OP_QUERY, 1'b0, 1, 1, 2, 2, 1'b0);
      send_item(OP_QUERY, 1'b0, 2, 3, 2, 3, 1'b0);
      send_item(OP_QUERY, 1'b0, 2, 0, 1, 3, 1'b0);
      send_item(OP_QUERY, 1'b0, 0, 3, 2, 2, 1'b0);
      send_item(OP_QUERY, 1'b0, 0, 0, 3, 3, 1'b0);
      send_item(OP_QUERY, 1'b0, 0, 0, 2, 4, 1'b0);
      send_item(OP_QUERY, 1'b1, 255, 255, 255, 255, 1'b0);
   endtask

   // largest rows and columns, including out-of-range register values
   task automatic test_extreme_sizes();
      set_size(511, 1);
      load_image(60, 1'b0);
      send_item(OP_QUERY, 1'b0, 0, 0, 255, 0, 1'b0);
      send_item(OP_QUERY, 1'b0, 0, 0, 255, 1, 1'b0);
      repeat (4) good_query(1'b1);
      set_size(1, 300);
      load_image(50, 1'b1);
      send_item(OP_QUERY, 1'b0, 0, 0, 0, 255, 1'b0);
      repeat (4) good_query(1'b1);
   endtask

   // output held off while queries keep coming, so the input stalls
   task automatic test_output_hold();
      set_size(5, 6);
      load_image(50, 1'b0);
      hold_left = 300;
      repeat (16) good_query(1'b0);
      drain();
   endtask

   // random sizes, densities and queries
   task automatic test_random_images();
      int start;
      start = items_sent;
      while (items_sent - start < 180) begin
         set_size($urandom_range(0, 7) == 0 ? $urandom_range(10, 16) : $urandom_range(1, 8),
                  $urandom_range(0, 7) == 0 ? $urandom_range(10, 16) : $urandom_range(1, 8));
         if ($urandom_range(0, 3) == 0) wild_query(1'b1);
         load_image($urandom_range(0, 100), 1'b1);
         repeat ($urandom_range(4, 14)) begin
            if ($urandom_range(0, 4) == 0) wild_query(1'b1);
            else good_query(1'b1);
            if ($urandom_range(0, 9) == 0)
               send_item(OP_LOAD, $urandom_range(0, 1), 0, 0, 0, 0, 1'b1);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_ROW_COUNT;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_LOAD;
      req_ch.pixel = 1'b0;
      req_ch.top_row = '0;
      req_ch.left_column = '0;
      req_ch.bottom_row = '0;
      req_ch.right_column = '0;
      rsp_ch.ready = 1'b0;
      hold_left = 0;
      stall_left = 0;
      fail_count = 0;
      answers_seen = 0;
      items_sent = 0;
      n_rows = 256;
      n_cols = 256;
      ld_row = 0;
      ld_col = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(OP_QUERY, 1'b0, 0, 0, 255, 255, 1'b0);
      test_tiny_image();
      test_directed_pattern();
      test_extreme_sizes();
      test_output_hold();
      test_random_images();
      drain();

      $display("covered %0d transfers in, %0d answers out over %0d cycles",
               items_sent, answers_seen, cycle_count);
      $display("sizes from 1x1 to 256 rows or columns, bad and early queries, output hold-off");
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- files.f -----
src/grvec_pkg.sv
src/grvec_if.sv
src/grvec_front.sv
src/grvec_back.sv
src/grid_region_vertex_edge_count.sv
tb/tb.sv
